// ===== design/mavg_pkg.sv =====
// Package for the moving average block with zero-run clear.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package mavg_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WIN_W      = 5;
	localparam int LIMIT_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_RUN_LIMIT = 1'b1;

	localparam logic [WIN_W-1:0]   WIN_RESET   = 5'd10;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd3;
	localparam logic [LIMIT_W-1:0] RUN_MAX     = 8'hFF;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Control strobes of the sample store: clear, write and read.
	typedef struct packed {
		logic clear;
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

// ===== design/mavg_ifs.sv =====
// Channel interfaces of the moving average block: sample requests in,
// average requests out. Depends on mavg_pkg.
interface mavg_in_if import mavg_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface mavg_out_if import mavg_pkg::*;;
	logic    valid;
	logic    ready;
	sample_t average;
	logic    was_cleared;

	modport source(output valid, output average, output was_cleared, input ready);
	modport sink(input valid, input average, input was_cleared, output ready);
endinterface

// ===== design/mavg_store.sv =====
// Sample store: one write port, one registered read port, per-entry valid
// bits so that a clear resets all entries together. Depends on mavg_pkg.
module mavg_store import mavg_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  store_ctl_t    ctl,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic [AW-1:0] raddr,
	output sample_t       rdata
);

	sample_t          mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	sample_t          rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// An entry never written since the last clear reads as zero.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= valid_q[raddr] ? mem_q[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/moving_average_with_zero_run_reset.sv =====
// Moving average of signed 16-bit samples with a clear on a run of
// non-positive samples. Depends on mavg_pkg, mavg_ifs and mavg_store.
//
// Usage:
//   samples: one request per 16-bit signed sample (valid/ready).
//   result : one request per sample with the window average (truncated
//            toward zero) and a flag that marks a clear (valid/ready).
//   cfg    : write port; index 0 is window_size (bits 4:0, 1 to MAX_TAPS;
//            others dropped), index 1 is zero_run_limit. Write only when idle.
// Sequence: a sample that completes the run goes straight to the done step,
//   and its zero result passes through res_avg_q to the output register.
//   Otherwise the position is wrapped, the window is summed one entry per
//   cycle through the store's read port into an accumulator of SW bits (20
//   for MAX_TAPS of 16), divided one quotient bit per cycle and signed, all
//   on one shared adder; a shrunk window wraps by repeated subtraction.
// samples.ready is high only while the sequencer is idle. The result sits
//   in an output register, so the next sample may be taken while it waits;
//   a stalled receiver holds the sequencer at its last step until free.
// Reset clears the store, position and run count, and loads window_size 10
//   and zero_run_limit 3.
module moving_average_with_zero_run_reset import mavg_pkg::*; #(
	parameter int MAX_TAPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	mavg_in_if.sink               samples,
	mavg_out_if.source            result
);

	localparam int PW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int PCW = $clog2(MAX_TAPS + 1);
	localparam int SW  = SAMPLE_W + PW;
	localparam int AW  = SW + 1;
	localparam int DCW = $clog2(SW + 1);
	localparam int XW  = (PCW > WIN_W) ? PCW : WIN_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WRAP = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_ABS  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SIGN = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]         state_q;
	logic [WIN_W-1:0]   ws_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [LIMIT_W-1:0] run_q;
	logic [PCW-1:0]     pos_q;
	logic [PCW-1:0]     rd_idx_q;
	logic               rd_pend_q;
	logic [SW-1:0]      acc_q;
	logic [WIN_W-1:0]   rem_q;
	logic [DCW-1:0]     div_cnt_q;
	logic               neg_q;
	sample_t            res_avg_q;
	logic               res_clr_q;
	logic               out_valid_q;
	sample_t            out_avg_q;
	logic               out_clr_q;

	logic               accept;
	logic               out_free;
	logic [LIMIT_W-1:0] run_next;
	logic               do_clear;
	logic               more_reads;
	logic [WIN_W:0]     shifted;
	store_ctl_t         store_ctl;
	sample_t            rdata;

	logic [AW-1:0]      op_a;
	logic [AW-1:0]      op_b;
	logic               op_sub;
	logic [AW-1:0]      alu_y;

	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_valid_q || result.ready;

	assign run_next = (samples.sample <= sample_t'(0))
		? ((run_q == RUN_MAX) ? RUN_MAX : run_q + 1'b1)
		: '0;
	assign do_clear = run_next >= limit_q;

	assign more_reads = (XW'(rd_idx_q) < XW'(ws_q)) && (rd_idx_q < PCW'(MAX_TAPS));
	assign shifted    = {rem_q, acc_q[SW-1]};

	// The one shared adder: summing, position wrap, magnitude, division steps
	// and the final sign all run through it.
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q)
			ST_WRAP: begin
				op_a   = AW'(pos_q);
				op_b   = AW'(ws_q);
				op_sub = 1'b1;
			end
			ST_SUM: begin
				op_a = {acc_q[SW-1], acc_q};
				op_b = {{(AW-SAMPLE_W){rdata[SAMPLE_W-1]}}, rdata};
			end
			ST_ABS: begin
				op_b   = {acc_q[SW-1], acc_q};
				op_sub = 1'b1;
			end
			ST_DIV: begin
				op_a   = AW'(shifted);
				op_b   = AW'(ws_q);
				op_sub = 1'b1;
			end
			ST_SIGN: begin
				op_b   = AW'(acc_q);
				op_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign alu_y = op_a + (op_b ^ {AW{op_sub}}) + AW'(op_sub);

	always_comb begin
		store_ctl.clear = accept && do_clear;
		store_ctl.wr_en = accept && !do_clear;
		store_ctl.rd_en = (state_q == ST_SUM) && more_reads;
	end

	mavg_store #(
		.DEPTH(MAX_TAPS),
		.AW   (PW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (store_ctl),
		.waddr (pos_q[PW-1:0]),
		.wdata (samples.sample),
		.raddr (rd_idx_q[PW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q    <= WIN_RESET;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WINDOW_SIZE: begin
					if (cfg_wdata[WIN_W-1:0] != '0 &&
							XW'(cfg_wdata[WIN_W-1:0]) <= XW'(MAX_TAPS)) begin
						ws_q <= cfg_wdata[WIN_W-1:0];
					end
				end
				REG_ZERO_RUN_LIMIT: begin
					limit_q <= cfg_wdata[LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			run_q     <= '0;
			pos_q     <= '0;
			rd_idx_q  <= '0;
			rd_pend_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			rd_pend_q <= store_ctl.rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (do_clear) begin
							run_q   <= '0;
							pos_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							run_q   <= run_next;
							pos_q   <= pos_q + 1'b1;
							state_q <= ST_WRAP;
						end
					end
				end
				ST_WRAP: begin
					// Reduce the next position modulo the window size.
					if (!alu_y[AW-1]) begin
						pos_q <= alu_y[PCW-1:0];
					end else begin
						rd_idx_q <= '0;
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (store_ctl.rd_en) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rd_pend_q) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					div_cnt_q <= DCW'(SW);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DCW'(1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; the quotient is shifted into acc_q as the dividend
	// shifts out of it.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && do_clear) begin
					res_avg_q <= '0;
					res_clr_q <= 1'b1;
				end
			end
			ST_WRAP: begin
				acc_q <= '0;
			end
			ST_SUM: begin
				if (rd_pend_q) begin
					acc_q <= alu_y[SW-1:0];
				end
			end
			ST_ABS: begin
				neg_q <= acc_q[SW-1];
				rem_q <= '0;
				if (acc_q[SW-1]) begin
					acc_q <= alu_y[SW-1:0];
				end
			end
			ST_DIV: begin
				if (!alu_y[AW-1]) begin
					rem_q <= alu_y[WIN_W-1:0];
					acc_q <= {acc_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= shifted[WIN_W-1:0];
					acc_q <= {acc_q[SW-2:0], 1'b0};
				end
			end
			ST_SIGN: begin
				res_avg_q <= neg_q ? alu_y[SAMPLE_W-1:0] : acc_q[SAMPLE_W-1:0];
				res_clr_q <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_avg_q <= res_avg_q;
			out_clr_q <= res_clr_q;
		end
	end

	assign samples.ready      = (state_q == ST_IDLE);
	assign result.valid       = out_valid_q;
	assign result.average     = out_avg_q;
	assign result.was_cleared = out_clr_q;

endmodule
